// ===== hw/rtl/frgbe_pkg.sv =====
// shared types and constants for the float rgb to rgbe packer
`timescale 1ns / 1ps

package frgbe_pkg;

  // 255.9999 as unsigned fixed point with 40 fraction bits, rounded to nearest
  localparam logic [47:0] ScaleQ40 = 48'hFFFF_F972_4745;
  localparam logic [15:0] ScaleHi  = ScaleQ40[47:32];
  localparam logic [31:0] ScaleLo  = ScaleQ40[31:0];

  // largest binary32 magnitude not above 1e-32
  localparam logic [30:0] NearBlackBits = 31'h0A4F_B11E;

  // exponent field of the max plus this gives e + 128
  localparam logic [7:0] ExpFieldToByte = 8'd2;

  // exponent field that pushes e + 128 past 255
  localparam logic [7:0] ExpFieldOvf = 8'd254;

  // all-ones binary32 exponent field: infinity or nan
  localparam logic [7:0] ExpFieldSpecial = 8'hFF;

  // per-pixel classification found by the front stage
  typedef struct packed {
    logic       not_finite;
    logic       near_black;
    logic       exp_ovf;
    logic [7:0] emax_field;
  } class_t;

endpackage

// ===== hw/rtl/frgbe_lane.sv =====
// one colour lane: scales a binary32 component to a byte against the shared exponent
`timescale 1ns / 1ps

module frgbe_lane (
  input  logic        clk_i,
  input  logic [31:0] comp_bits_i,
  input  logic [7:0]  emax_field_i,
  output logic [7:0]  byte_o
);

  logic [23:0] mant;
  logic [7:0]  ef;
  logic        zero;

  logic [55:0] plo_q, plo_d;
  logic [39:0] phi_q, phi_d;
  logic [7:0]  ef_q;
  logic        zero_q;

  logic [71:0] prod;
  logic [7:0]  exp_gap;
  logic [7:0]  byte_q, byte_d;

  // unpack the component, subnormals take field one without the hidden bit
  always_comb begin
    if (comp_bits_i[30:23] == 8'd0) begin
      ef   = 8'd1;
      mant = {1'b0, comp_bits_i[22:0]};
    end else begin
      ef   = comp_bits_i[30:23];
      mant = {1'b1, comp_bits_i[22:0]};
    end
    zero = comp_bits_i[31] || (mant == 24'd0);
  end

  // first stage: mantissa times the scale constant as two partial products
  assign plo_d = 56'(mant) * 56'(frgbe_pkg::ScaleLo);
  assign phi_d = 40'(mant) * 40'(frgbe_pkg::ScaleHi);

  always_ff @(posedge clk_i) begin
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    ef_q   <= ef;
    zero_q <= zero;
  end

  // second stage: join partials, keep the top byte and shift by exponent gap
  assign prod    = {phi_q, 32'd0} + {16'd0, plo_q};
  assign exp_gap = emax_field_i - ef_q;

  always_comb begin
    if (zero_q || (ef_q > emax_field_i) || (exp_gap > 8'd7)) begin
      byte_d = 8'd0;
    end else begin
      byte_d = prod[71:64] >> exp_gap[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== hw/rtl/frgbe_classify.sv =====
// front stage: finds the largest positive component and the special cases
`timescale 1ns / 1ps

module frgbe_classify (
  input  logic                clk_i,
  input  logic [31:0]         red_bits_i,
  input  logic [31:0]         green_bits_i,
  input  logic [31:0]         blue_bits_i,
  output frgbe_pkg::class_t   cls_o
);

  logic [30:0]       red_mag, green_mag, blue_mag;
  logic [30:0]       rg_max, max_mag;
  frgbe_pkg::class_t cls_d, cls_q;

  // negative components count as zero in the max search
  assign red_mag   = red_bits_i[31]   ? 31'd0 : red_bits_i[30:0];
  assign green_mag = green_bits_i[31] ? 31'd0 : green_bits_i[30:0];
  assign blue_mag  = blue_bits_i[31]  ? 31'd0 : blue_bits_i[30:0];

  // positive floats order like their bit patterns
  assign rg_max  = (green_mag > red_mag) ? green_mag : red_mag;
  assign max_mag = (blue_mag > rg_max) ? blue_mag : rg_max;

  // classification of the pixel
  always_comb begin
    cls_d.not_finite = (red_bits_i[30:23] == frgbe_pkg::ExpFieldSpecial)
                    || (green_bits_i[30:23] == frgbe_pkg::ExpFieldSpecial)
                    || (blue_bits_i[30:23] == frgbe_pkg::ExpFieldSpecial);
    cls_d.near_black = (max_mag <= frgbe_pkg::NearBlackBits);
    cls_d.exp_ovf    = (max_mag[30:23] >= frgbe_pkg::ExpFieldOvf);
    cls_d.emax_field = max_mag[30:23];
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  assign cls_o = cls_q;

endmodule

// ===== hw/rtl/float_rgb_to_rgbe_pack.sv =====
// top level: packs a binary32 rgb pixel into rgbe bytes with three lanes and a merge stage
`timescale 1ns / 1ps

// channel   direction  signals
// command   in         start_i, busy_o, red_bits_i, green_bits_i, blue_bits_i, last_pixel_i
// result    out        result_valid_o, red/green/blue_mantissa_o, shared_exponent_o,
//                      out_of_range_o, last_out_o
//
// an item is taken at every clock with start_i high; busy_o stays low
// each item passes through the three registered stages (partial products,
// byte shift, merge); one item per cycle sustained
// reset clears only the valid pipeline; items in flight are dropped
// the receiver cannot stall: result_valid_o lasts exactly one cycle

module float_rgb_to_rgbe_pack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] red_bits_i,
  input  logic [31:0] green_bits_i,
  input  logic [31:0] blue_bits_i,
  input  logic        last_pixel_i,
  output logic        result_valid_o,
  output logic [7:0]  red_mantissa_o,
  output logic [7:0]  green_mantissa_o,
  output logic [7:0]  blue_mantissa_o,
  output logic [7:0]  shared_exponent_o,
  output logic        out_of_range_o,
  output logic        last_out_o
);

  logic              accept;
  logic              v1_q, v2_q, v3_q;
  logic              last1_q, last2_q, last3_q;
  frgbe_pkg::class_t cls1, cls2_q;
  logic [7:0]        red_byte, green_byte, blue_byte;

  logic [7:0]        red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [7:0]        expo_q, expo_d;
  logic              oor_q, oor_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // front classification, result is valid in stage one
  frgbe_classify u_classify (
    .clk_i        (clk_i),
    .red_bits_i   (red_bits_i),
    .green_bits_i (green_bits_i),
    .blue_bits_i  (blue_bits_i),
    .cls_o        (cls1)
  );

  // three scaling lanes, bytes are valid in stage two
  frgbe_lane u_lane_red (
    .clk_i        (clk_i),
    .comp_bits_i  (red_bits_i),
    .emax_field_i (cls1.emax_field),
    .byte_o       (red_byte)
  );

  frgbe_lane u_lane_green (
    .clk_i        (clk_i),
    .comp_bits_i  (green_bits_i),
    .emax_field_i (cls1.emax_field),
    .byte_o       (green_byte)
  );

  frgbe_lane u_lane_blue (
    .clk_i        (clk_i),
    .comp_bits_i  (blue_bits_i),
    .emax_field_i (cls1.emax_field),
    .byte_o       (blue_byte)
  );

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload alignment for the merge stage
  always_ff @(posedge clk_i) begin
    last1_q <= last_pixel_i;
    last2_q <= last1_q;
    last3_q <= last2_q;
    cls2_q  <= cls1;
  end

  // merge: special cases override the lane bytes
  always_comb begin
    red_d   = 8'd0;
    green_d = 8'd0;
    blue_d  = 8'd0;
    expo_d  = 8'd0;
    oor_d   = 1'b0;
    if (cls2_q.not_finite) begin
      oor_d = 1'b1;
    end else if (cls2_q.near_black) begin
      oor_d = 1'b0;
    end else if (cls2_q.exp_ovf) begin
      oor_d = 1'b1;
    end else begin
      red_d   = red_byte;
      green_d = green_byte;
      blue_d  = blue_byte;
      expo_d  = cls2_q.emax_field + frgbe_pkg::ExpFieldToByte;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    expo_q  <= expo_d;
    oor_q   <= oor_d;
  end

  assign result_valid_o    = v3_q;
  assign red_mantissa_o    = red_q;
  assign green_mantissa_o  = green_q;
  assign blue_mantissa_o   = blue_q;
  assign shared_exponent_o = expo_q;
  assign out_of_range_o    = oor_q;
  assign last_out_o        = last3_q;

`ifndef SYNTHESIS
  // every result traces back to an item taken at the head of the valid pipeline
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 3))
    else $error("result without a matching item");

  // out of range results carry all-zero bytes
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |->
      (shared_exponent_o == 8'd0 && red_mantissa_o == 8'd0
       && green_mantissa_o == 8'd0 && blue_mantissa_o == 8'd0))
    else $error("out of range result has nonzero bytes");

  // a zero exponent byte means a zeroed pixel
  a_zero_expo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && shared_exponent_o == 8'd0) |->
      (red_mantissa_o == 8'd0 && green_mantissa_o == 8'd0 && blue_mantissa_o == 8'd0))
    else $error("zero exponent with nonzero mantissa");
`endif

endmodule

// ===== verif/tb.sv =====
// testbench for the binary32 rgb to rgbe pixel packer
`timescale 1ns / 1ps

module tb;

  // largest binary32 magnitude that still counts as black
  localparam logic [31:0] BlackLimitBits = 32'h0A4F_B11E;
  // 255.9999 in unsigned fixed point, 40 fraction bits
  localparam logic [47:0] ByteScaleQ40   = 48'd281474866759493;
  localparam logic [7:0]  ExpFieldInf    = 8'hFF;
  localparam logic [7:0]  ExpFieldTooBig = 8'd254;
  localparam logic [7:0]  ExpExcessAdd   = 8'd2;
  localparam int unsigned WatchdogCycles = 400;
  localparam int unsigned RandomPixels   = 525;

  // one packed rgbe result, field order matches the result ports
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] expo;
    logic       oor;
    logic       last;
  } rgbe_t;

  // expected rgbe results and their comparison against the block
  class rgbe_scoreboard;
    rgbe_t       pending_packs[$];
    int unsigned mismatches;
    int unsigned pixels;
    int unsigned flagged;
    int unsigned blacks;

    function new();
      mismatches = 0;
      pixels     = 0;
      flagged    = 0;
      blacks     = 0;
    endfunction

    // one component scaled to the shared exponent of the max
    function automatic logic [7:0] scale_lane(logic [31:0] bits, logic [7:0] emax);
      logic [7:0]  ef;
      logic [23:0] mant;
      logic [71:0] prod;
      int unsigned shift_amt;
      if (bits[31]) return 8'd0;
      ef   = bits[30:23];
      mant = {1'b0, bits[22:0]};
      if (ef == 8'd0) ef = 8'd1;
      else mant[23] = 1'b1;
      if (mant == 24'd0) return 8'd0;
      if (ef > emax) return 8'd0;
      shift_amt = emax - ef;
      if (shift_amt >= 32) return 8'd0;
      prod = 72'(mant) * 72'(ByteScaleQ40);
      prod = prod >> (64 + shift_amt);
      return prod[7:0];
    endfunction

    // full rgbe encoding of one pixel
    function automatic rgbe_t pack_rgbe(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                        logic last);
      rgbe_t       res;
      logic [31:0] lanes [3];
      logic [31:0] maxbits;
      logic [7:0]  emax;
      res      = '0;
      res.last = last;
      lanes[0] = r;
      lanes[1] = g;
      lanes[2] = b;
      // infinity or nan anywhere wins over everything else
      if (r[30:23] == ExpFieldInf || g[30:23] == ExpFieldInf || b[30:23] == ExpFieldInf) begin
        res.oor = 1'b1;
        return res;
      end
      // positive finite floats order like their bit patterns
      maxbits = '0;
      for (int i = 0; i < 3; i++) begin
        if (!lanes[i][31] && lanes[i] > maxbits) maxbits = lanes[i];
      end
      if (maxbits <= BlackLimitBits) return res;
      emax = maxbits[30:23];
      if (emax >= ExpFieldTooBig) begin
        res.oor = 1'b1;
        return res;
      end
      res.red   = scale_lane(r, emax);
      res.green = scale_lane(g, emax);
      res.blue  = scale_lane(b, emax);
      res.expo  = emax + ExpExcessAdd;
      return res;
    endfunction

    function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b, logic last);
      rgbe_t want;
      want = pack_rgbe(r, g, b, last);
      pending_packs.push_back(want);
      pixels++;
      if (want.oor) flagged++;
      else if (want.expo == 8'd0) blacks++;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_pack(rgbe_t got);
      rgbe_t want;
      if (pending_packs.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual %0h", $time, got);
        return;
      end
      want = pending_packs.pop_front();
      compare_field("red_mantissa", want.red, got.red);
      compare_field("green_mantissa", want.green, got.green);
      compare_field("blue_mantissa", want.blue, got.blue);
      compare_field("shared_exponent", want.expo, got.expo);
      compare_field("out_of_range", 8'(want.oor), 8'(got.oor));
      compare_field("last_out", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] red_bits_i;
  logic [31:0] green_bits_i;
  logic [31:0] blue_bits_i;
  logic        last_pixel_i;
  logic        result_valid_o;
  logic [7:0]  red_mantissa_o;
  logic [7:0]  green_mantissa_o;
  logic [7:0]  blue_mantissa_o;
  logic [7:0]  shared_exponent_o;
  logic        out_of_range_o;
  logic        last_out_o;

  logic           took_item;
  int unsigned    quiet_cycles;
  rgbe_scoreboard sb = new();

  float_rgb_to_rgbe_pack u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .red_bits_i        (red_bits_i),
    .green_bits_i      (green_bits_i),
    .blue_bits_i       (blue_bits_i),
    .last_pixel_i      (last_pixel_i),
    .result_valid_o    (result_valid_o),
    .red_mantissa_o    (red_mantissa_o),
    .green_mantissa_o  (green_mantissa_o),
    .blue_mantissa_o   (blue_mantissa_o),
    .shared_exponent_o (shared_exponent_o),
    .out_of_range_o    (out_of_range_o),
    .last_out_o        (last_out_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // accepted items, results and the watchdog, all sampled at the rising edge
  initial took_item = 1'b0;
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    took_item = rst_ni && start_i && !busy_o;
    if (took_item) sb.note_pixel(red_bits_i, green_bits_i, blue_bits_i, last_pixel_i);
    if (result_valid_o) begin
      sb.check_pack({red_mantissa_o, green_mantissa_o, blue_mantissa_o, shared_exponent_o,
                     out_of_range_o, last_out_o});
    end
    if (took_item || result_valid_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogCycles) begin
      $display("%0t watchdog: no item or result for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // present one item after a gap and hold it until it is taken
  task automatic send_pixel(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b,
                            input logic last, input int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    red_bits_i   <= r;
    green_bits_i <= g;
    blue_bits_i  <= b;
    last_pixel_i <= last;
    do @(negedge clk_i); while (!took_item);
  endtask

  // stop sending until every expected result is back
  task automatic drain_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending_packs.size() > 0);
  endtask

  // one random component, mostly a normal value near the pixel's exponent
  function automatic logic [31:0] rand_lane(logic [7:0] base);
    int unsigned kind;
    int unsigned drop;
    logic [7:0]  ef;
    kind = $urandom_range(0, 99);
    drop = $urandom_range(0, 4);
    ef   = (base > drop) ? base - 8'(drop) : 8'd0;
    if (kind < 60) return {($urandom_range(0, 9) == 0), ef, 23'($urandom)};
    if (kind < 70) return $urandom;
    if (kind < 76) return {1'($urandom), 31'd0};
    if (kind < 82) return {1'($urandom), 8'd0, 23'($urandom)};
    if (kind < 85) return {1'($urandom), ExpFieldInf, 23'($urandom)};
    if (kind < 92) return BlackLimitBits + 32'($urandom_range(0, 4)) - 32'd2;
    return {1'b1, 8'($urandom_range(1, 254)), 23'($urandom)};
  endfunction

  // stimulus
  initial begin : stim
    logic [7:0]  base;
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    logic        burst;
    int unsigned gap;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    red_bits_i   = '0;
    green_bits_i = '0;
    blue_bits_i  = '0;
    last_pixel_i = 1'b0;
    burst        = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners, back to back
    send_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
    send_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 0);
    send_pixel(32'h0A4F_B11E, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
    send_pixel(32'h0A4F_B11F, 32'h0A4F_B11E, 32'h0000_0001, 1'b0, 0);
    send_pixel(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 0);
    send_pixel(32'h3F80_0000, 32'h7FC0_0000, 32'h0000_0000, 1'b0, 0);
    send_pixel(32'h0000_0000, 32'h0000_0000, 32'hFF80_0000, 1'b0, 0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 0);
    send_pixel(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, 0);
    send_pixel(32'h7F00_0000, 32'h3F80_0000, 32'h0000_0000, 1'b1, 0);
    send_pixel(32'h7EFF_FFFF, 32'h7E80_0000, 32'h7E00_0000, 1'b0, 0);
    send_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0, 0);
    send_pixel(32'h3F00_0000, 32'h3F7F_FFFF, 32'h3E80_0000, 1'b1, 0);
    send_pixel(32'hBF80_0000, 32'h3F80_0000, 32'hC000_0000, 1'b0, 0);
    send_pixel(32'h007F_FFFF, 32'h0000_0001, 32'h0080_0000, 1'b1, 0);
    send_pixel(32'h0B00_0000, 32'h007F_FFFF, 32'h0000_0001, 1'b0, 0);
    send_pixel(32'h2000_0000, 32'h0C80_0000, 32'h1C00_0000, 1'b0, 0);
    send_pixel(32'h2C00_0000, 32'h1CFF_FFFF, 32'h1C7F_FFFF, 1'b1, 0);
    send_pixel(32'hFF7F_FFFF, 32'h3F80_0000, 32'h0000_0000, 1'b0, 0);
    send_pixel(32'h42C8_0000, 32'h42C7_FFFF, 32'h0000_0000, 1'b1, 0);
    send_pixel(32'h3F7F_FFFF, 32'h3F7F_FFFF, 32'h3F7F_FFFF, 1'b0, 0);
    send_pixel(32'h0080_0000, 32'h7F7F_FFFF, 32'h8000_0001, 1'b1, 0);
    drain_results();

    // random pixels, mostly with components of similar magnitude
    for (int n = 0; n < RandomPixels; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n % 150 == 75) drain_results();
      gap = burst ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 9) == 0) base = 8'($urandom_range(250, 254));
      else base = 8'($urandom_range(1, 253));
      if ($urandom_range(0, 99) < 85) begin
        r = rand_lane(base);
        g = rand_lane(base);
        b = rand_lane(base);
      end else begin
        r = $urandom;
        g = $urandom;
        b = $urandom;
      end
      send_pixel(r, g, b, 1'($urandom), gap);
    end

    drain_results();
    repeat (8) @(negedge clk_i);

    $display("covered %0d pixels: %0d flagged out of range, %0d near black, rest scaled",
             sb.pixels, sb.flagged, sb.blacks);
    if (sb.pending_packs.size() > 0) begin
      $display("%0t %0d expected results never arrived", $time, sb.pending_packs.size());
    end
    if (sb.mismatches == 0 && sb.pending_packs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
